// ----- rtl/sqltok_pkg.sv -----
`timescale 1ns / 1ps

package sqltok_pkg;

	// Width of a token position as it leaves the block.
	localparam int unsigned TOK_POS_W = 12;

	// Lexer modes.
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_STRING = 3'd1;
	localparam logic [2:0] MODE_TICK   = 3'd2;
	localparam logic [2:0] MODE_INT    = 3'd3;
	localparam logic [2:0] MODE_REAL   = 3'd4;
	localparam logic [2:0] MODE_WORD   = 3'd5;

	// Token kinds.
	localparam logic [2:0] KIND_STRING = 3'd0;
	localparam logic [2:0] KIND_NAME   = 3'd1;
	localparam logic [2:0] KIND_INT    = 3'd2;
	localparam logic [2:0] KIND_REAL   = 3'd3;
	localparam logic [2:0] KIND_OP     = 3'd4;

	typedef logic [TOK_POS_W-1:0] tok_pos_t;

	// Lexer control state that does not depend on the statement length.
	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] prev_byte;
		logic       pend_valid;
		logic [7:0] pend_byte;
		logic       exp_seen;
	} lex_ctrl_t;

	// One finished token.
	typedef struct packed {
		logic [2:0] kind;
		tok_pos_t   first_pos;
		tok_pos_t   last_pos;
		logic       last;
	} tok_t;

endpackage

// ----- rtl/sqltok_in_if.sv -----
`timescale 1ns / 1ps

interface sqltok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

// ----- rtl/sqltok_out_if.sv -----
`timescale 1ns / 1ps

interface sqltok_out_if;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       token_kind;
	logic [sqltok_pkg::TOK_POS_W-1:0] token_begin;
	logic [sqltok_pkg::TOK_POS_W-1:0] token_end;
	logic                             last_of_run;

	modport source (output valid, output token_kind, output token_begin, output token_end,
		output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_begin, input token_end,
		input last_of_run, output ready);
endinterface

// ----- rtl/sqltok_step.sv -----
`timescale 1ns / 1ps

module sqltok_step #(
	parameter int unsigned MAX_LEN = 4096,
	parameter int unsigned POS_W   = 12
) (
	input  logic [7:0]            c_byte,
	input  sqltok_pkg::lex_ctrl_t ctrl,
	input  logic [POS_W-1:0]      pos,
	input  logic [POS_W-1:0]      start,
	output sqltok_pkg::lex_ctrl_t ctrl_nxt,
	output logic [POS_W-1:0]      pos_nxt,
	output logic [POS_W-1:0]      start_nxt,
	output sqltok_pkg::tok_t      tok0,
	output sqltok_pkg::tok_t      tok1,
	output logic [1:0]            tok_cnt
);
	import sqltok_pkg::*;

	localparam int unsigned EXT_W = (POS_W > TOK_POS_W) ? POS_W : TOK_POS_W;
	localparam logic [POS_W:0] POS_MAX = (POS_W + 1)'(MAX_LEN - 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TICK  = 8'h60;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	logic [POS_W:0]   st_inc;
	logic [POS_W:0]   pos_inc;
	logic [POS_W-1:0] st_sat;
	logic [POS_W-1:0] pos_sat;
	logic [EXT_W-1:0] pos_x;
	logic [EXT_W-1:0] pos_m1_x;
	logic [EXT_W-1:0] st_x;
	logic [EXT_W-1:0] st_p1_x;
	logic             is_digit;
	logic             is_letter;
	logic             is_quote;
	logic             esc_prev;
	logic             op_pair;
	logic             do_scan;
	logic             first_v;
	logic             scan_v;
	tok_t             first_tok;
	tok_t             scan_tok;

	// Byte classes.
	assign is_digit  = (c_byte >= 8'h30) && (c_byte <= 8'h39);
	assign is_letter = ((c_byte >= 8'h61) && (c_byte <= 8'h7A)) ||
		((c_byte >= 8'h41) && (c_byte <= 8'h5A)) || (c_byte == 8'h5F);
	assign is_quote  = (c_byte == CH_SQ) || (c_byte == CH_DQ);
	assign esc_prev  = (ctrl.prev_byte == CH_BSL);
	assign op_pair   = ((ctrl.pend_byte == CH_BANG) && (c_byte == CH_EQ)) ||
		((ctrl.pend_byte == CH_LT) && ((c_byte == CH_GT) || (c_byte == CH_EQ))) ||
		((ctrl.pend_byte == CH_GT) && (c_byte == CH_EQ));

	// Saturating position arithmetic.
	assign st_inc   = {1'b0, start} + (POS_W + 1)'(1);
	assign pos_inc  = {1'b0, pos} + (POS_W + 1)'(1);
	assign st_sat   = (st_inc > POS_MAX) ? POS_MAX[POS_W-1:0] : st_inc[POS_W-1:0];
	assign pos_sat  = (pos_inc > POS_MAX) ? POS_MAX[POS_W-1:0] : pos_inc[POS_W-1:0];
	assign pos_x    = EXT_W'(pos);
	assign pos_m1_x = pos_x - EXT_W'(1);
	assign st_x     = EXT_W'(start);
	assign st_p1_x  = EXT_W'(st_sat);

	// Mode update, the token that closes, and the rescan of the same byte.
	always_comb begin
		ctrl_nxt  = ctrl;
		pos_nxt   = pos;
		start_nxt = start;
		first_v   = 1'b0;
		first_tok = '0;
		scan_v    = 1'b0;
		scan_tok  = '0;
		do_scan   = 1'b0;

		if (c_byte == CH_NUL) begin
			// End of statement: flush a held operator, drop any open token.
			first_v = ctrl.pend_valid;
			first_tok = '{KIND_OP, st_x[TOK_POS_W-1:0], st_x[TOK_POS_W-1:0], 1'b0};
			ctrl_nxt.mode = MODE_IDLE;
			ctrl_nxt.prev_byte = '0;
			ctrl_nxt.pend_valid = 1'b0;
			ctrl_nxt.pend_byte = '0;
			ctrl_nxt.exp_seen = 1'b0;
			pos_nxt = '0;
			start_nxt = '0;
		end else begin
			unique case (ctrl.mode)
				MODE_STRING: begin
					if (is_quote && !esc_prev) begin
						first_v = 1'b1;
						first_tok = '{KIND_STRING, st_p1_x[TOK_POS_W-1:0],
							pos_m1_x[TOK_POS_W-1:0], 1'b0};
						ctrl_nxt.mode = MODE_IDLE;
					end
				end
				MODE_TICK: begin
					if ((c_byte == CH_TICK) && !esc_prev) begin
						first_v = 1'b1;
						first_tok = '{KIND_NAME, st_p1_x[TOK_POS_W-1:0],
							pos_m1_x[TOK_POS_W-1:0], 1'b0};
						ctrl_nxt.mode = MODE_IDLE;
					end
				end
				MODE_INT: begin
					if ((c_byte == CH_DOT) || (c_byte == CH_E)) begin
						ctrl_nxt.mode = MODE_REAL;
						ctrl_nxt.exp_seen = (c_byte == CH_E);
					end else if (!is_digit) begin
						first_v = 1'b1;
						first_tok = '{KIND_INT, st_x[TOK_POS_W-1:0],
							pos_m1_x[TOK_POS_W-1:0], 1'b0};
						ctrl_nxt.mode = MODE_IDLE;
						do_scan = 1'b1;
					end
				end
				MODE_REAL: begin
					ctrl_nxt.exp_seen = 1'b0;
					// A minus right after the exponent mark stays in the real.
					if (!(ctrl.exp_seen && (c_byte == CH_MINUS)) && !is_digit) begin
						first_v = 1'b1;
						first_tok = '{KIND_REAL, st_x[TOK_POS_W-1:0],
							pos_m1_x[TOK_POS_W-1:0], 1'b0};
						ctrl_nxt.mode = MODE_IDLE;
						do_scan = 1'b1;
					end
				end
				MODE_WORD: begin
					if (!is_letter && !is_digit) begin
						first_v = 1'b1;
						first_tok = '{KIND_NAME, st_x[TOK_POS_W-1:0],
							pos_m1_x[TOK_POS_W-1:0], 1'b0};
						ctrl_nxt.mode = MODE_IDLE;
						do_scan = 1'b1;
					end
				end
				default: begin
					ctrl_nxt.mode = MODE_IDLE;
					if (ctrl.pend_valid) begin
						ctrl_nxt.pend_valid = 1'b0;
						ctrl_nxt.pend_byte = '0;
						first_v = 1'b1;
						if (op_pair) begin
							first_tok = '{KIND_OP, st_x[TOK_POS_W-1:0],
								pos_x[TOK_POS_W-1:0], 1'b0};
						end else begin
							first_tok = '{KIND_OP, st_x[TOK_POS_W-1:0],
								st_x[TOK_POS_W-1:0], 1'b0};
							do_scan = 1'b1;
						end
					end else begin
						do_scan = 1'b1;
					end
				end
			endcase

			// Idle scan: open a token, hold a possible two-byte operator,
			// skip white space or emit a one-byte operator.
			if (do_scan) begin
				if (is_quote) begin
					ctrl_nxt.mode = MODE_STRING;
					start_nxt = pos;
				end else if (c_byte == CH_TICK) begin
					ctrl_nxt.mode = MODE_TICK;
					start_nxt = pos;
				end else if (is_digit || (c_byte == CH_MINUS)) begin
					ctrl_nxt.mode = MODE_INT;
					ctrl_nxt.exp_seen = 1'b0;
					start_nxt = pos;
				end else if (is_letter) begin
					ctrl_nxt.mode = MODE_WORD;
					start_nxt = pos;
				end else if ((c_byte == CH_SP) || (c_byte == CH_TAB) ||
					(c_byte == CH_LF) || (c_byte == CH_CR)) begin
					start_nxt = start;
				end else if ((c_byte == CH_BANG) || (c_byte == CH_LT) ||
					(c_byte == CH_GT)) begin
					ctrl_nxt.pend_valid = 1'b1;
					ctrl_nxt.pend_byte = c_byte;
					start_nxt = pos;
				end else begin
					scan_v = 1'b1;
					scan_tok = '{KIND_OP, pos_x[TOK_POS_W-1:0], pos_x[TOK_POS_W-1:0], 1'b0};
				end
			end

			ctrl_nxt.prev_byte = c_byte;
			pos_nxt = pos_sat;
		end
	end

	// Pack the tokens of this byte in order and mark the final one.
	always_comb begin
		if (first_v) begin
			tok0 = first_tok;
			tok0.last = !scan_v;
			tok1 = scan_tok;
			tok1.last = 1'b1;
			tok_cnt = scan_v ? 2'd2 : 2'd1;
		end else begin
			tok0 = scan_tok;
			tok0.last = 1'b1;
			tok1 = '0;
			tok_cnt = scan_v ? 2'd1 : 2'd0;
		end
	end

endmodule

// ----- rtl/sql_statement_tokenizer_top.sv -----
`timescale 1ns / 1ps

// SQL statement tokenizer.
// char_in takes one statement byte per beat; the byte 0 ends the statement and
// returns the lexer to its reset state. token_out delivers one token per beat
// with its kind, inclusive begin and end positions and last_of_run, which marks
// the final token caused by one byte (a byte causes zero, one or two tokens).
// Path: a byte is captured in the input register and its tokens then move to
// the result register, from which token_out offers them.
// Throughput: one byte per cycle while each byte causes at most one token and the
// receiver takes every token; a byte that causes two tokens holds the two-entry
// result register until both leave, so the next byte waits in the input register.
// The input register keeps accepting a byte while a finished token waits, so
// char_in.ready only drops when the input register is full and the result
// register still holds a token that this cycle does not drain.
// Reset clears the lexer to idle mode at position zero and empties both
// registers. When the receiver stalls, the current token holds steady and the
// input side fills and then deasserts ready; nothing is lost.
// Positions count up to MAX_LEN-1 and then stay there.
module sql_statement_tokenizer_top #(
	parameter int unsigned MAX_LEN = 4096
) (
	input logic         clk,
	input logic         arst_n,
	sqltok_in_if.sink   char_in,
	sqltok_out_if.source token_out
);
	import sqltok_pkg::*;

	localparam int unsigned POS_W = $clog2(MAX_LEN);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	lex_ctrl_t        ctrl_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] start_q;
	tok_t             res_s2 [2];
	logic [1:0]       cnt_s2;

	lex_ctrl_t        ctrl_nxt;
	logic [POS_W-1:0] pos_nxt;
	logic [POS_W-1:0] start_nxt;
	tok_t             tok0;
	tok_t             tok1;
	logic [1:0]       tok_cnt;
	logic             in_beat;
	logic             out_beat;
	logic             advance;

	// The byte in the input register moves on once the result register
	// is empty or drains its last token this cycle.
	assign out_beat = token_out.valid && token_out.ready;
	assign advance  = valid_s1 && ((cnt_s2 == 2'd0) || ((cnt_s2 == 2'd1) && out_beat));
	assign in_beat  = char_in.valid && char_in.ready;
	assign char_in.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			byte_s1 <= char_in.char_byte;
		end
	end

	sqltok_step #(
		.MAX_LEN(MAX_LEN),
		.POS_W  (POS_W)
	) u_step (
		.c_byte   (byte_s1),
		.ctrl     (ctrl_q),
		.pos      (pos_q),
		.start    (start_q),
		.ctrl_nxt (ctrl_nxt),
		.pos_nxt  (pos_nxt),
		.start_nxt(start_nxt),
		.tok0     (tok0),
		.tok1     (tok1),
		.tok_cnt  (tok_cnt)
	);

	// Lexer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '{MODE_IDLE, 8'h00, 1'b0, 8'h00, 1'b0};
			pos_q <= '0;
			start_q <= '0;
		end else if (advance) begin
			ctrl_q <= ctrl_nxt;
			pos_q <= pos_nxt;
			start_q <= start_nxt;
		end
	end

	// Result register: up to two tokens, shifted out one per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
		end else if (advance) begin
			cnt_s2 <= tok_cnt;
		end else if (out_beat) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2[0] <= tok0;
			res_s2[1] <= tok1;
		end else if (out_beat) begin
			res_s2[0] <= res_s2[1];
		end
	end

	assign token_out.valid       = (cnt_s2 != 2'd0);
	assign token_out.token_kind  = res_s2[0].kind;
	assign token_out.token_begin = res_s2[0].first_pos;
	assign token_out.token_end   = res_s2[0].last_pos;
	assign token_out.last_of_run = res_s2[0].last;

endmodule

// ----- rtl/sqltok_checker.sv -----
`timescale 1ns / 1ps

module sqltok_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  out_kind,
	input logic [11:0] out_begin,
	input logic [11:0] out_end,
	input logic        out_last
);
	import sqltok_pkg::*;

	// A token offered and not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("token dropped while stalled");

	// A stalled token keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({out_kind, out_begin, out_end, out_last}))
		else $error("token changed while stalled");

	// A token that is not the last of its byte is followed at once by the next.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("second token of a byte missing");

	// With no token waiting, the input side always takes a byte.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// Only the five token kinds leave the block.
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind <= KIND_OP))
		else $error("token kind out of range");

endmodule

bind sql_statement_tokenizer_top sqltok_checker u_sqltok_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (char_in.ready),
	.out_valid(token_out.valid),
	.out_ready(token_out.ready),
	.out_kind (token_out.token_kind),
	.out_begin(token_out.token_begin),
	.out_end  (token_out.token_end),
	.out_last (token_out.last_of_run)
);
